### design/gls_pkg.sv
// gls_pkg: shared types and constants of the grid laplacian stencil
// holds default sizes, register indexes and reset values, command codes, stencil coefficient codes and fsm states
// no dependencies

package gls_pkg;

	// default sizes for the top level parameters
	localparam int MAX_WIDTH_DEF   = 64;
	localparam int MAX_HEIGHT_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INV_SPACING_SQ = 2'd2;

	localparam logic [6:0]  GRID_WIDTH_RST     = 7'd64;
	localparam logic [6:0]  GRID_HEIGHT_RST    = 7'd64;
	localparam logic [31:0] INV_SPACING_SQ_RST = 32'd65536;

	// smallest grid size the boundary formulas work with
	localparam int GRID_MIN = 4;

	// input commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// weight applied to one memory read
	typedef enum logic [2:0] {
		COEF_NONE,
		COEF_P1,
		COEF_M1,
		COEF_P2,
		COEF_M2,
		COEF_P4,
		COEF_M5
	} coef_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_ABS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_SAT
	} state_t;

endpackage

### design/gls_ram.sv
// gls_ram: generic simple dual port ram, one write and one registered read port
// uses gls_pkg for default sizes

module gls_ram #(
	parameter int WIDTH = gls_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = gls_pkg::MAX_WIDTH_DEF * gls_pkg::MAX_HEIGHT_DEF,
	localparam int ABITS = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [ABITS-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [ABITS-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/grid_laplacian_stencil.sv
// grid_laplacian_stencil: top level, grid sample store and laplacian query engine
// uses gls_pkg and one gls_ram instance for the frame store

// A write beat stores a signed Q16.16 sample at (row, col) when accepted and
// the block is ready for the next beat. A query beat computes the discrete
// laplacian at (row, col): interior cells use the five point stencil, edge
// cells use the central difference along the edge and the one-sided
// 2,-5,4,-1 difference across it, corners use one-sided differences on both
// axes. The sum is scaled by inv_spacing_sq (unsigned Q16.16), rounded half
// away from zero and saturated to 32 bits with the saturated flag. A query
// inside the grid keeps the block busy until its result is loaded: eight
// reads through the single read port of the frame memory, one per cycle
// (four cells per axis), a read pipe drain, the magnitude, the two 32x32
// partial products on one shared multiplier, the sum and rounding, and
// saturation, which waits for a free output register. A query outside the
// in-use grid skips to saturation and returns zero. The result sits in an
// output register, so the next item is taken while it waits. The frame
// store has no reset: a cell must be written before a query reads it. The
// user must write configuration only while idle; the block does not check.

module grid_laplacian_stencil #(
	parameter int MAX_WIDTH   = gls_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = gls_pkg::MAX_HEIGHT_DEF,
	parameter int SAMPLE_BITS = gls_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [gls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gls_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [5:0]                         row,
	input  logic [5:0]                         col,
	input  logic signed [31:0]                 sample,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [31:0]                 laplacian,
	output logic                               saturated
);

	// storage geometry
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ABITS = $clog2(DEPTH);

	// grid size compare width, wide enough for the 7 bit registers and the maxima
	localparam int CW0 = $clog2(MAX_WIDTH + 1) > 7 ? $clog2(MAX_WIDTH + 1) : 7;
	localparam int CW  = $clog2(MAX_HEIGHT + 1) > CW0 ? $clog2(MAX_HEIGHT + 1) : CW0;

	// stencil sum: at most 24 * 2^(SAMPLE_BITS-1) in magnitude
	localparam int AW  = SAMPLE_BITS + 6;
	// magnitude padded so it splits into a 32 bit low part and a nonempty high part
	localparam int MPW = AW > 33 ? AW : 33;
	localparam int PW  = MPW + 32;
	localparam int RW  = PW - 16;
	// sample extension width before truncation to the stored width
	localparam int XW  = SAMPLE_BITS > 32 ? SAMPLE_BITS : 32;

	// config registers
	logic [6:0]  grid_width_q;
	logic [6:0]  grid_height_q;
	logic [31:0] inv_q;

	// control
	gls_pkg::state_t state_q, state_d;
	logic [2:0]      step_q;
	gls_pkg::coef_t  coef_s1;

	// query context
	logic [5:0] row_q;
	logic [5:0] col_q;
	logic       zero_q;
	logic       cedge_lo_q, cedge_hi_q;
	logic       redge_lo_q, redge_hi_q;

	// datapath
	logic signed [AW-1:0] acc_q;
	logic                 neg_q;
	logic [MPW-1:0]       mag_q;
	logic [63:0]          plo_q;
	logic [63:0]          phi_q;
	logic [PW-1:0]        prod_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] laplacian_q;
	logic               saturated_q;

	// memory ports
	logic                   mem_we;
	logic [ABITS-1:0]       mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic                   mem_re;
	logic [ABITS-1:0]       mem_raddr;
	logic [SAMPLE_BITS-1:0] mem_rdata;

	// accept-time decode
	logic          in_fire;
	logic [CW-1:0] w_eff, h_eff;
	logic          in_grid;
	logic          in_store;
	logic [XW-1:0] sample_x;

	// read step decode
	logic                 axis_v;
	logic [1:0]           tap;
	logic [6:0]           pos_c, pos_sel;
	logic                 e_lo, e_hi;
	logic [6:0]           rd_r, rd_c;
	gls_pkg::coef_t       coef_d;
	logic signed [AW-1:0] rd_ext, term;

	// multiplier and result
	logic [31:0]     mul_a;
	logic [63:0]     mul_p;
	logic [RW-1:0]   rnd;
	logic            sat_pos, sat_neg;
	logic            load_out;

	assign in_ready = (state_q == gls_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// grid size clamped to [4, max]
	always_comb begin
		if (grid_width_q < 7'(gls_pkg::GRID_MIN)) begin
			w_eff = CW'(gls_pkg::GRID_MIN);
		end else if (CW'(grid_width_q) > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(grid_width_q);
		end
		if (grid_height_q < 7'(gls_pkg::GRID_MIN)) begin
			h_eff = CW'(gls_pkg::GRID_MIN);
		end else if (CW'(grid_height_q) > CW'(MAX_HEIGHT)) begin
			h_eff = CW'(MAX_HEIGHT);
		end else begin
			h_eff = CW'(grid_height_q);
		end
	end

	assign in_grid  = (CW'(row) < h_eff) && (CW'(col) < w_eff);
	assign in_store = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);

	// writes go straight into the frame memory on the accepting beat
	assign sample_x  = XW'($unsigned(sample));
	assign mem_we    = in_fire && (command == gls_pkg::CMD_WRITE) && in_store;
	assign mem_waddr = ABITS'(32'(row) * MAX_WIDTH + 32'(col));
	assign mem_wdata = sample_x[SAMPLE_BITS-1:0];

	// read step: steps 0-3 walk along the row, steps 4-7 along the column
	assign axis_v  = step_q[2];
	assign tap     = step_q[1:0];
	assign pos_c   = axis_v ? {1'b0, row_q} : {1'b0, col_q};
	assign e_lo    = axis_v ? redge_lo_q : cedge_lo_q;
	assign e_hi    = axis_v ? redge_hi_q : cedge_hi_q;

	always_comb begin
		pos_sel = pos_c;
		coef_d  = gls_pkg::COEF_NONE;
		if (e_lo || e_hi) begin
			// one-sided difference toward the inside
			pos_sel = e_lo ? 7'(tap) : (pos_c - 7'(tap));
			case (tap)
				2'd0:    coef_d = gls_pkg::COEF_P2;
				2'd1:    coef_d = gls_pkg::COEF_M5;
				2'd2:    coef_d = gls_pkg::COEF_P4;
				default: coef_d = gls_pkg::COEF_M1;
			endcase
		end else begin
			// central difference, fourth tap unused and parked on the center cell
			case (tap)
				2'd0: begin
					pos_sel = pos_c - 7'd1;
					coef_d  = gls_pkg::COEF_P1;
				end
				2'd1: begin
					pos_sel = pos_c;
					coef_d  = gls_pkg::COEF_M2;
				end
				2'd2: begin
					pos_sel = pos_c + 7'd1;
					coef_d  = gls_pkg::COEF_P1;
				end
				default: begin
					pos_sel = pos_c;
					coef_d  = gls_pkg::COEF_NONE;
				end
			endcase
		end
		if (state_q != gls_pkg::ST_READ) begin
			coef_d = gls_pkg::COEF_NONE;
		end
	end

	assign rd_r      = axis_v ? pos_sel : {1'b0, row_q};
	assign rd_c      = axis_v ? {1'b0, col_q} : pos_sel;
	assign mem_re    = (state_q == gls_pkg::ST_READ);
	assign mem_raddr = ABITS'(32'(rd_r) * MAX_WIDTH + 32'(rd_c));

	gls_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// weighted read data, arriving in the cycle after its address
	assign rd_ext = AW'(signed'(mem_rdata));

	always_comb begin
		case (coef_s1)
			gls_pkg::COEF_P1: term = rd_ext;
			gls_pkg::COEF_M1: term = -rd_ext;
			gls_pkg::COEF_P2: term = rd_ext <<< 1;
			gls_pkg::COEF_M2: term = -(rd_ext <<< 1);
			gls_pkg::COEF_P4: term = rd_ext <<< 2;
			gls_pkg::COEF_M5: term = -((rd_ext <<< 2) + rd_ext);
			default:          term = '0;
		endcase
	end

	// one shared 32x32 multiplier: low half of the magnitude, then the high half
	assign mul_a = (state_q == gls_pkg::ST_MUL_HI) ? 32'(mag_q[MPW-1:32]) : mag_q[31:0];
	assign mul_p = 64'(mul_a) * 64'(inv_q);

	// rounded magnitude and clip checks
	assign rnd     = prod_q[PW-1:16];
	assign sat_pos = |rnd[RW-1:31];
	assign sat_neg = (|rnd[RW-1:32]) || (rnd[31] && (|rnd[30:0]));

	assign load_out = (state_q == gls_pkg::ST_SAT) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gls_pkg::ST_IDLE: begin
				if (in_fire && (command == gls_pkg::CMD_QUERY)) begin
					state_d = in_grid ? gls_pkg::ST_READ : gls_pkg::ST_SAT;
				end
			end
			gls_pkg::ST_READ: begin
				if (step_q == 3'd7) begin
					state_d = gls_pkg::ST_DRAIN;
				end
			end
			gls_pkg::ST_DRAIN:  state_d = gls_pkg::ST_ABS;
			gls_pkg::ST_ABS:    state_d = gls_pkg::ST_MUL_LO;
			gls_pkg::ST_MUL_LO: state_d = gls_pkg::ST_MUL_HI;
			gls_pkg::ST_MUL_HI: state_d = gls_pkg::ST_SUM;
			gls_pkg::ST_SUM:    state_d = gls_pkg::ST_SAT;
			gls_pkg::ST_SAT: begin
				if (load_out) begin
					state_d = gls_pkg::ST_IDLE;
				end
			end
			default: state_d = gls_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gls_pkg::ST_IDLE;
			step_q        <= '0;
			coef_s1       <= gls_pkg::COEF_NONE;
			out_valid_q   <= 1'b0;
			grid_width_q  <= gls_pkg::GRID_WIDTH_RST;
			grid_height_q <= gls_pkg::GRID_HEIGHT_RST;
			inv_q         <= gls_pkg::INV_SPACING_SQ_RST;
		end else begin
			state_q <= state_d;
			coef_s1 <= coef_d;
			if (in_fire) begin
				step_q <= '0;
			end else if (state_q == gls_pkg::ST_READ) begin
				step_q <= step_q + 3'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					gls_pkg::REG_GRID_WIDTH:     grid_width_q  <= cfg_data[6:0];
					gls_pkg::REG_GRID_HEIGHT:    grid_height_q <= cfg_data[6:0];
					gls_pkg::REG_INV_SPACING_SQ: inv_q         <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q      <= row;
			col_q      <= col;
			zero_q     <= !in_grid;
			cedge_lo_q <= (col == 6'd0);
			cedge_hi_q <= (CW'(col) == w_eff - CW'(1));
			redge_lo_q <= (row == 6'd0);
			redge_hi_q <= (CW'(row) == h_eff - CW'(1));
			acc_q      <= '0;
		end else begin
			acc_q <= acc_q + term;
		end
		if (state_q == gls_pkg::ST_ABS) begin
			neg_q <= acc_q[AW-1];
			mag_q <= MPW'(acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q));
		end
		if (state_q == gls_pkg::ST_MUL_LO) begin
			plo_q <= mul_p;
		end
		if (state_q == gls_pkg::ST_MUL_HI) begin
			phi_q <= mul_p;
		end
		if (state_q == gls_pkg::ST_SUM) begin
			// exact product plus half an lsb of the Q16.16 result
			prod_q <= PW'(plo_q) + (PW'(phi_q) << 32) + PW'(32'h0000_8000);
		end
		if (load_out) begin
			if (zero_q) begin
				laplacian_q <= '0;
				saturated_q <= 1'b0;
			end else if (neg_q) begin
				laplacian_q <= sat_neg ? 32'sh8000_0000 : signed'(-rnd[31:0]);
				saturated_q <= sat_neg;
			end else begin
				laplacian_q <= sat_pos ? 32'sh7FFF_FFFF : signed'(rnd[31:0]);
				saturated_q <= sat_pos;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign laplacian = laplacian_q;
	assign saturated = saturated_q;

endmodule
